/* hw/rtl/sdf_pkg.sv */
`default_nettype none

package sdf_pkg;

    // Fraction bits of positions, delta, forces and velocity.
    localparam int FRAC_BITS = 14;

    // Field widths.
    localparam int ACT_W     = 2;
    localparam int DT_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TGT_W     = 16;
    localparam int POS_W     = 18;
    localparam int VEL_W     = 20;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    // Shared multiplier: A operand, B operand and registered product.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Intermediate widths.
    localparam int TGT_SUM_W = 25;
    localparam int DELTA_W   = POS_W + 1;
    localparam int MAG_W     = DELTA_W + 1;
    localparam int DMULT_W   = MUL_B_W;
    localparam int FORCE_W   = MUL_A_W;
    localparam int VEL_SUM_W = 34;
    localparam int POS_SUM_W = 22;

    // Rescaling shifts.
    localparam int STEP_SHIFT = 24 - FRAC_BITS;
    localparam int GAIN_SHIFT = FRAC_BITS - 8;
    localparam int PULL_SHIFT = 8;
    localparam int DT_SHIFT   = 16;
    localparam int Q14_SHL    = (FRAC_BITS >= 14) ? (FRAC_BITS - 14) : 0;
    localparam int Q14_SHR    = (FRAC_BITS < 14) ? (14 - FRAC_BITS) : 0;

    // Move commands.
    localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_MAX     = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_STIFFNESS    = 16'd6400;
    localparam logic [CFG_W-1:0] RST_MOVE_RATE    = 16'd512;
    localparam logic [CFG_W-1:0] RST_DAMPING_BASE = 16'd1024;
    localparam logic [CFG_W-1:0] RST_DAMP_MIN     = 16'd1638;
    localparam logic [CFG_W-1:0] RST_DAMP_MAX     = 16'd16384;

    // Operand pair routed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_STEP,
        MUL_DAMP,
        MUL_PULL,
        MUL_FORCE,
        MUL_VEL
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     load_target;
        logic     load_delta;
        logic     load_damp;
        logic     load_force;
        logic     load_vel;
        logic     load_pos;
        logic     load_out;
    } sdf_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/sdf_dp.sv */
`default_nettype none

module sdf_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdf_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic [sdf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire sdf_pkg::sdf_cmd_t              cmd,
    output logic      [sdf_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int A_W   = sdf_pkg::MUL_A_W;
    localparam int B_W   = sdf_pkg::MUL_B_W;
    localparam int P_W   = sdf_pkg::PROD_W;
    localparam int CW    = sdf_pkg::CFG_W;
    localparam int DTW   = sdf_pkg::DT_W;
    localparam int AW    = sdf_pkg::ACT_W;
    localparam int TW    = sdf_pkg::TGT_W;
    localparam int PW    = sdf_pkg::POS_W;
    localparam int VW    = sdf_pkg::VEL_W;
    localparam int TSW   = sdf_pkg::TGT_SUM_W;
    localparam int DW    = sdf_pkg::DELTA_W;
    localparam int MW    = sdf_pkg::MAG_W;
    localparam int DMW   = sdf_pkg::DMULT_W;
    localparam int FW    = sdf_pkg::FORCE_W;
    localparam int VSW   = sdf_pkg::VEL_SUM_W;
    localparam int PSW   = sdf_pkg::POS_SUM_W;
    localparam int PAD_W = sdf_pkg::M_TDATA_W - TW - PW - VW;

    localparam logic signed [TSW-1:0] TGT_ONE = TSW'(1 << sdf_pkg::FRAC_BITS);
    localparam logic signed [VSW-1:0] VEL_HI  = VSW'((1 << (VW - 1)) - 1);
    localparam logic signed [VSW-1:0] VEL_LO  = -VSW'(1 << (VW - 1));
    localparam logic signed [PSW-1:0] POS_HI  = PSW'((1 << (PW - 1)) - 1);
    localparam logic signed [PSW-1:0] POS_LO  = -PSW'(1 << (PW - 1));

    // Configuration registers.
    logic [CW-1:0] stiffness_reg;
    logic [CW-1:0] move_rate_reg;
    logic [CW-1:0] damping_base_reg;
    logic [CW-1:0] damp_min_reg;
    logic [CW-1:0] damp_max_reg;

    // Captured request.
    logic [AW-1:0]  action_reg;
    logic [DTW-1:0] dt_reg;

    // Follower state.
    logic signed [TW-1:0] target_reg;
    logic signed [PW-1:0] position_reg;
    logic signed [VW-1:0] velocity_reg;

    // Working registers.
    logic signed [P_W-1:0] prod_reg;
    logic signed [DW-1:0]  delta_reg;
    logic signed [DMW-1:0] dmult_reg;
    logic signed [FW-1:0]  damp_reg;
    logic signed [FW-1:0]  force_reg;
    logic [sdf_pkg::M_TDATA_W-1:0] out_reg;

    // Combinational values.
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [B_W-1:0] dt_b;
    logic signed [TSW-1:0] tgt_step;
    logic signed [TSW-1:0] tgt_base;
    logic signed [TSW-1:0] tgt_sum;
    logic signed [TSW-1:0] tgt_clamped;
    logic signed [TW-1:0]  target_next;
    logic signed [DW-1:0]  delta_c;
    logic signed [MW-1:0]  delta_x;
    logic signed [MW-1:0]  abs_x;
    logic [MW-1:0]         mag;
    logic [MW-1:0]         mag_lo;
    logic [MW-1:0]         mag_hi;
    logic [MW-1:0]         mag_t;
    logic [MW-1:0]         mag_c;
    logic signed [DMW-1:0] base_s;
    logic signed [DMW-1:0] dmult_c;
    logic signed [P_W-1:0] neg_prod;
    logic signed [FW-1:0]  damp_c;
    logic signed [FW-1:0]  pull_c;
    logic signed [FW-1:0]  force_c;
    logic signed [VSW-1:0] vel_sum;
    logic signed [VW-1:0]  velocity_next;
    logic signed [PSW-1:0] pos_sum;
    logic signed [PW-1:0]  position_next;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg    <= sdf_pkg::RST_STIFFNESS;
            move_rate_reg    <= sdf_pkg::RST_MOVE_RATE;
            damping_base_reg <= sdf_pkg::RST_DAMPING_BASE;
            damp_min_reg     <= sdf_pkg::RST_DAMP_MIN;
            damp_max_reg     <= sdf_pkg::RST_DAMP_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdf_pkg::CFG_STIFFNESS:    stiffness_reg    <= cfg_data;
                sdf_pkg::CFG_MOVE_RATE:    move_rate_reg    <= cfg_data;
                sdf_pkg::CFG_DAMPING_BASE: damping_base_reg <= cfg_data;
                sdf_pkg::CFG_DAMP_MIN:     damp_min_reg     <= cfg_data;
                sdf_pkg::CFG_DAMP_MAX:     damp_max_reg     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        dt_b = $signed(B_W'(dt_reg));
        unique case (cmd.mul_sel)
            sdf_pkg::MUL_STEP:
            begin
                mul_a = $signed(A_W'(move_rate_reg));
                mul_b = dt_b;
            end
            sdf_pkg::MUL_DAMP:
            begin
                mul_a = A_W'(velocity_reg);
                mul_b = dmult_reg;
            end
            sdf_pkg::MUL_PULL:
            begin
                mul_a = A_W'(delta_reg);
                mul_b = $signed(B_W'(stiffness_reg));
            end
            sdf_pkg::MUL_FORCE:
            begin
                mul_a = force_reg;
                mul_b = dt_b;
            end
            sdf_pkg::MUL_VEL:
            begin
                mul_a = A_W'(velocity_reg);
                mul_b = dt_b;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Target move and clamp to [-1, 1].
    always_comb
    begin
        tgt_step = TSW'(prod_reg >>> sdf_pkg::STEP_SHIFT);
        tgt_base = TSW'(target_reg);
        priority if (action_reg == sdf_pkg::ACT_LEFT)
            tgt_sum = tgt_base - tgt_step;
        else if (action_reg == sdf_pkg::ACT_RIGHT)
            tgt_sum = tgt_base + tgt_step;
        else
            tgt_sum = tgt_base;
        priority if (tgt_sum > TGT_ONE)
            tgt_clamped = TGT_ONE;
        else if (tgt_sum < -TGT_ONE)
            tgt_clamped = -TGT_ONE;
        else
            tgt_clamped = tgt_sum;
        target_next = TW'(tgt_clamped);
    end

    // Distance, clamped magnitude and damping multiplier.
    always_comb
    begin
        delta_c = DW'(position_reg) - DW'(target_reg);
        delta_x = MW'(delta_c);
        abs_x   = (delta_x < 0) ? -delta_x : delta_x;
        mag     = $unsigned(abs_x);
        mag_lo  = (MW'(damp_min_reg) << sdf_pkg::Q14_SHL) >> sdf_pkg::Q14_SHR;
        mag_hi  = (MW'(damp_max_reg) << sdf_pkg::Q14_SHL) >> sdf_pkg::Q14_SHR;
        // Lower bound first, then upper bound, so crossed bounds give the upper one.
        mag_t   = (mag < mag_lo) ? mag_lo : mag;
        mag_c   = (mag_t > mag_hi) ? mag_hi : mag_t;
        base_s  = $signed(DMW'(damping_base_reg)) <<< sdf_pkg::GAIN_SHIFT;
        dmult_c = base_s - $signed(DMW'(mag_c));
    end

    // Forces, velocity and position from the registered product.
    always_comb
    begin
        neg_prod      = -prod_reg;
        damp_c        = FW'(neg_prod >>> sdf_pkg::FRAC_BITS);
        pull_c        = FW'(neg_prod >>> sdf_pkg::PULL_SHIFT);
        force_c       = pull_c + damp_reg;
        vel_sum       = VSW'(velocity_reg) + VSW'(prod_reg >>> sdf_pkg::DT_SHIFT);
        priority if (vel_sum > VEL_HI)
            velocity_next = VW'(VEL_HI);
        else if (vel_sum < VEL_LO)
            velocity_next = VW'(VEL_LO);
        else
            velocity_next = VW'(vel_sum);
        pos_sum       = PSW'(position_reg) + PSW'(prod_reg >>> sdf_pkg::DT_SHIFT);
        priority if (pos_sum > POS_HI)
            position_next = PW'(POS_HI);
        else if (pos_sum < POS_LO)
            position_next = PW'(POS_LO);
        else
            position_next = PW'(pos_sum);
    end

    // Follower state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            position_reg <= '0;
            velocity_reg <= '0;
        end
        else
        begin
            if (cmd.load_target)
                target_reg <= target_next;
            if (cmd.load_vel)
                velocity_reg <= velocity_next;
            if (cmd.load_pos)
                position_reg <= position_next;
        end
    end

    // Request capture, product and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= s_tdata[AW-1:0];
            dt_reg     <= s_tdata[AW+DTW-1:AW];
        end
        if (cmd.mul_en)
            prod_reg <= P_W'(mul_a) * P_W'(mul_b);
        if (cmd.load_delta)
        begin
            delta_reg <= delta_c;
            dmult_reg <= dmult_c;
        end
        if (cmd.load_damp)
            damp_reg <= damp_c;
        if (cmd.load_force)
            force_reg <= force_c;
        if (cmd.load_out)
            out_reg <= {{PAD_W{1'b0}}, velocity_reg, position_reg, target_reg};
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/sdf_ctrl.sv */
`default_nettype none

module sdf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output sdf_pkg::sdf_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSTEP,
        ST_TGT,
        ST_DELTA,
        ST_MDAMP,
        ST_MPULL,
        ST_FORCE,
        ST_MVEL,
        ST_VEL,
        ST_MPOS,
        ST_POS,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencing and command decode.
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.mul_sel   = sdf_pkg::MUL_STEP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MSTEP;
                end
            end
            ST_MSTEP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sdf_pkg::MUL_STEP;
                state_next  = ST_TGT;
            end
            ST_TGT:
            begin
                cmd.load_target = 1'b1;
                state_next      = ST_DELTA;
            end
            ST_DELTA:
            begin
                cmd.load_delta = 1'b1;
                state_next     = ST_MDAMP;
            end
            ST_MDAMP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sdf_pkg::MUL_DAMP;
                state_next  = ST_MPULL;
            end
            ST_MPULL:
            begin
                cmd.load_damp = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = sdf_pkg::MUL_PULL;
                state_next    = ST_FORCE;
            end
            ST_FORCE:
            begin
                cmd.load_force = 1'b1;
                state_next     = ST_MVEL;
            end
            ST_MVEL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sdf_pkg::MUL_FORCE;
                state_next  = ST_VEL;
            end
            ST_VEL:
            begin
                cmd.load_vel = 1'b1;
                state_next   = ST_MPOS;
            end
            ST_MPOS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sdf_pkg::MUL_VEL;
                state_next  = ST_POS;
            end
            ST_POS:
            begin
                cmd.load_pos = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (out_free)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/spring_damper_follower_top.sv */
`default_nettype none

// Channel   Direction  Request contents
// s_*       in         one tick: move command and time step
// m_*       out        target, position and velocity after the tick
// cfg_*     in         register write: index and 16-bit value
//
// A request runs through the sequencer states one product at a time, and a new request
// is not accepted until the last one is done, as its five products share one 32x24
// multiplier. The next request is accepted in the cycle after the result is
// loaded into the output register, even while that result still waits for m_tready.
// Reset clears target, position and velocity and loads the default gains.
// A stalled result holds the sequence in its last step until the output frees.

module spring_damper_follower_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [1:0] action, [17:2] time_step, [23:18] zero
    input  wire logic [sdf_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [15:0] target_position, [33:16] current_position,
    // [53:34] current_velocity, [55:54] zero
    output logic      [sdf_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdf_pkg::CFG_W-1:0]      cfg_data
);

    sdf_pkg::sdf_cmd_t cmd;

    // Sequencer.
    sdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Arithmetic, state and configuration.
    sdf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_spring_damper_follower_top.sv */
`timescale 1ns / 100ps

// Follower state as it leaves the block after one tick.
typedef struct {
    logic signed [sdf_pkg::TGT_W-1:0] target;
    logic signed [sdf_pkg::POS_W-1:0] position;
    logic signed [sdf_pkg::VEL_W-1:0] velocity;
} follower_state_t;

// Tracks the spring-damper follower and checks every result against it.
class follower_tracker;
    longint stiffness;
    longint move_rate;
    longint damping_base;
    longint damp_min;
    longint damp_max;
    longint target;
    longint position;
    longint velocity;
    follower_state_t expected_states[$];
    int mismatches;

    function new();
        stiffness    = longint'(sdf_pkg::RST_STIFFNESS);
        move_rate    = longint'(sdf_pkg::RST_MOVE_RATE);
        damping_base = longint'(sdf_pkg::RST_DAMPING_BASE);
        damp_min     = longint'(sdf_pkg::RST_DAMP_MIN);
        damp_max     = longint'(sdf_pkg::RST_DAMP_MAX);
        target       = 0;
        position     = 0;
        velocity     = 0;
        mismatches   = 0;
    endfunction

    static function longint clamp(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Mirror of a register write; unknown indexes are ignored.
    function void write_reg(logic [sdf_pkg::CFG_IDX_W-1:0] idx,
                            logic [sdf_pkg::CFG_W-1:0] value);
        case (idx)
            sdf_pkg::CFG_STIFFNESS:    stiffness    = longint'(value);
            sdf_pkg::CFG_MOVE_RATE:    move_rate    = longint'(value);
            sdf_pkg::CFG_DAMPING_BASE: damping_base = longint'(value);
            sdf_pkg::CFG_DAMP_MIN:     damp_min     = longint'(value);
            sdf_pkg::CFG_DAMP_MAX:     damp_max     = longint'(value);
            default: ;
        endcase
    endfunction

    // One semi-implicit Euler step for an accepted tick request.
    function void note_tick(logic [sdf_pkg::ACT_W-1:0] act, logic [sdf_pkg::DT_W-1:0] dt);
        longint one;
        longint span;
        longint step;
        longint delta;
        longint mag;
        longint lo;
        longint hi;
        longint dmult;
        longint damp;
        longint pull;
        longint push;
        longint new_vel;
        longint new_pos;
        follower_state_t st;
        one  = longint'(1) << sdf_pkg::FRAC_BITS;
        span = longint'(dt);

        // Move the target and keep it within -1..1.
        step = (move_rate * span) >>> sdf_pkg::STEP_SHIFT;
        if (act == sdf_pkg::ACT_LEFT)
            target = clamp(target - step, -one, one);
        else if (act == sdf_pkg::ACT_RIGHT)
            target = clamp(target + step, -one, one);

        // Distance term of the damping, max bound applied after min bound.
        delta = position - target;
        mag   = (delta < 0) ? -delta : delta;
        lo    = (damp_min << sdf_pkg::Q14_SHL) >> sdf_pkg::Q14_SHR;
        hi    = (damp_max << sdf_pkg::Q14_SHL) >> sdf_pkg::Q14_SHR;
        if (mag < lo)
            mag = lo;
        if (mag > hi)
            mag = hi;

        dmult = damping_base * (longint'(1) << sdf_pkg::GAIN_SHIFT) - mag;
        damp  = (-dmult * velocity) >>> sdf_pkg::FRAC_BITS;
        pull  = (-stiffness * delta) >>> sdf_pkg::PULL_SHIFT;
        push  = pull + damp;

        new_vel = clamp(velocity + ((push * span) >>> sdf_pkg::DT_SHIFT),
                        -(longint'(1) << (sdf_pkg::VEL_W - 1)),
                        (longint'(1) << (sdf_pkg::VEL_W - 1)) - 1);
        new_pos = clamp(position + ((new_vel * span) >>> sdf_pkg::DT_SHIFT),
                        -(longint'(1) << (sdf_pkg::POS_W - 1)),
                        (longint'(1) << (sdf_pkg::POS_W - 1)) - 1);
        velocity = new_vel;
        position = new_pos;

        st.target   = target[sdf_pkg::TGT_W-1:0];
        st.position = position[sdf_pkg::POS_W-1:0];
        st.velocity = velocity[sdf_pkg::VEL_W-1:0];
        expected_states.push_back(st);
    endfunction

    function int pending();
        return expected_states.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Compares one accepted result with the oldest expected state.
    task check_result(logic [sdf_pkg::M_TDATA_W-1:0] data);
        follower_state_t st;
        if (expected_states.size() == 0)
        begin
            report_mismatch("result with no tick pending, target",
                            longint'($signed(data[0 +: sdf_pkg::TGT_W])), 0);
            return;
        end
        st = expected_states.pop_front();
        if (data[0 +: sdf_pkg::TGT_W] !== st.target)
            report_mismatch("target_position",
                            longint'($signed(data[0 +: sdf_pkg::TGT_W])),
                            longint'(st.target));
        if (data[sdf_pkg::TGT_W +: sdf_pkg::POS_W] !== st.position)
            report_mismatch("current_position",
                            longint'($signed(data[sdf_pkg::TGT_W +: sdf_pkg::POS_W])),
                            longint'(st.position));
        if (data[sdf_pkg::TGT_W + sdf_pkg::POS_W +: sdf_pkg::VEL_W] !== st.velocity)
            report_mismatch("current_velocity",
                            longint'($signed(data[sdf_pkg::TGT_W + sdf_pkg::POS_W +:
                                                  sdf_pkg::VEL_W])),
                            longint'(st.velocity));
    endtask

    // Any state still waiting at the end never came out of the block.
    task check_leftovers();
        follower_state_t st;
        while (expected_states.size() != 0)
        begin
            st = expected_states.pop_front();
            report_mismatch("missing result, target", 0, longint'(st.target));
        end
    endtask
endclass

module tb_spring_damper_follower_top;

    localparam int AW  = sdf_pkg::ACT_W;
    localparam int DTW = sdf_pkg::DT_W;
    localparam int CW  = sdf_pkg::CFG_W;
    localparam int IW  = sdf_pkg::CFG_IDX_W;

    localparam logic [AW-1:0]  ACT_NONE   = 2'd0;
    localparam logic [AW-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [DTW-1:0] DT_MAX     = '1;
    localparam logic [CW-1:0]  CFG_MAX    = '1;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 50;
    localparam int SETTLE       = 16;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sdf_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [sdf_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    // When set, neither side inserts gaps between requests.
    bit no_idle = 1'b0;
    int unsigned cycles = 0;
    follower_tracker tracker = new();

    spring_damper_follower_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one tick request; called and returns at a falling edge.
    task automatic send_tick(input logic [AW-1:0] act, input logic [DTW-1:0] dt);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 6));
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = '0;
        s_tdata[0 +: AW] = act;
        s_tdata[AW +: DTW] = dt;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_tick(act, dt);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        tracker.write_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Holds the sender until every pending result has been taken.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Random gain: mostly near the default, sometimes the extremes.
    function automatic logic [CW-1:0] pick_reg(input logic [CW-1:0] dflt);
        int unsigned hi;
        int unsigned r;
        hi = (int'(dflt) * 2 > int'(CFG_MAX)) ? int'(CFG_MAX) : int'(dflt) * 2;
        case ($urandom_range(0, 7))
            0, 1, 2: r = $urandom_range(int'(dflt) / 2, hi);
            3:       r = int'(dflt);
            4:       r = 0;
            5:       r = int'(CFG_MAX);
            default: r = $urandom_range(0, int'(CFG_MAX));
        endcase
        return r[CW-1:0];
    endfunction

    // Mostly frame-sized time steps, with zero, full and random ones.
    function automatic logic [DTW-1:0] pick_step();
        int unsigned r;
        case ($urandom_range(0, 9))
            0:       r = 0;
            1:       r = int'(DT_MAX);
            2, 3:    r = $urandom_range(0, int'(DT_MAX));
            default: r = $urandom_range(0, 4095);
        endcase
        return r[DTW-1:0];
    endfunction

    function automatic logic [AW-1:0] pick_action();
        case ($urandom_range(0, 9))
            0:       return ACT_UNUSED;
            1, 2, 3: return ACT_NONE;
            4, 5, 6: return sdf_pkg::ACT_LEFT;
            default: return sdf_pkg::ACT_RIGHT;
        endcase
    endfunction

    // Result side: takes every result, after a random stall unless no_idle is set.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : int'($urandom_range(0, 6));
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            tracker.check_result(m_tdata);
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed ticks, then random phases.
    initial
    begin
        int unsigned spare_idx;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Default gains: full-step moves that hit both target clamps.
        send_tick(sdf_pkg::ACT_RIGHT, DT_MAX);
        send_tick(ACT_NONE, '0);
        send_tick(ACT_UNUSED, DT_MAX);
        send_tick(sdf_pkg::ACT_LEFT, DT_MAX);
        send_tick(sdf_pkg::ACT_LEFT, DT_MAX);
        send_tick(ACT_NONE, DT_MAX);
        send_tick(ACT_NONE, DT_MAX);
        send_tick(sdf_pkg::ACT_RIGHT, 16'd1);
        send_tick(ACT_NONE, '0);

        // Stiff spring, zero damping from crossed bounds and a zero base drive saturation.
        wait_drained();
        write_reg(sdf_pkg::CFG_STIFFNESS, CFG_MAX);
        write_reg(sdf_pkg::CFG_MOVE_RATE, CFG_MAX);
        write_reg(sdf_pkg::CFG_DAMPING_BASE, '0);
        write_reg(sdf_pkg::CFG_DAMP_MIN, CFG_MAX);
        write_reg(sdf_pkg::CFG_DAMP_MAX, '0);
        for (int i = int'(sdf_pkg::CFG_DAMP_MAX) + 1; i < (1 << IW); i++)
            write_reg(IW'(i), '0);
        send_tick(sdf_pkg::ACT_RIGHT, DT_MAX);
        send_tick(ACT_NONE, DT_MAX);
        send_tick(ACT_NONE, DT_MAX);
        send_tick(sdf_pkg::ACT_LEFT, DT_MAX);
        send_tick(ACT_NONE, DT_MAX);
        send_tick(ACT_NONE, DT_MAX);

        // All gains zero: the target cannot move and the state only drifts.
        wait_drained();
        write_reg(sdf_pkg::CFG_STIFFNESS, '0);
        write_reg(sdf_pkg::CFG_MOVE_RATE, '0);
        write_reg(sdf_pkg::CFG_DAMPING_BASE, '0);
        write_reg(sdf_pkg::CFG_DAMP_MIN, '0);
        write_reg(sdf_pkg::CFG_DAMP_MAX, '0);
        send_tick(sdf_pkg::ACT_RIGHT, DT_MAX);
        send_tick(ACT_NONE, DT_MAX);
        send_tick(sdf_pkg::ACT_LEFT, DT_MAX);

        // Random phases, each with its own gains; every other one without gaps.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
            begin
                write_reg(sdf_pkg::CFG_STIFFNESS, sdf_pkg::RST_STIFFNESS);
                write_reg(sdf_pkg::CFG_MOVE_RATE, sdf_pkg::RST_MOVE_RATE);
                write_reg(sdf_pkg::CFG_DAMPING_BASE, sdf_pkg::RST_DAMPING_BASE);
                write_reg(sdf_pkg::CFG_DAMP_MIN, sdf_pkg::RST_DAMP_MIN);
                write_reg(sdf_pkg::CFG_DAMP_MAX, sdf_pkg::RST_DAMP_MAX);
            end
            else
            begin
                write_reg(sdf_pkg::CFG_STIFFNESS, pick_reg(sdf_pkg::RST_STIFFNESS));
                write_reg(sdf_pkg::CFG_MOVE_RATE, pick_reg(sdf_pkg::RST_MOVE_RATE));
                write_reg(sdf_pkg::CFG_DAMPING_BASE, pick_reg(sdf_pkg::RST_DAMPING_BASE));
                write_reg(sdf_pkg::CFG_DAMP_MIN, pick_reg(sdf_pkg::RST_DAMP_MIN));
                write_reg(sdf_pkg::CFG_DAMP_MAX, pick_reg(sdf_pkg::RST_DAMP_MAX));
                spare_idx = $urandom_range(int'(sdf_pkg::CFG_DAMP_MAX) + 1, (1 << IW) - 1);
                write_reg(spare_idx[IW-1:0], pick_reg(CFG_MAX));
            end
            no_idle = (p % 2 == 1);
            for (int i = 0; i < PHASE_TICKS; i++)
                send_tick(pick_action(), pick_step());
        end

        // Let the last results out, then look for stragglers.
        no_idle = 1'b0;
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        tracker.check_leftovers();

        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
